// ===== hw/rtl/ps2md_pkg.sv =====
// ============================================================================
// ps2md_pkg
// Shared types and constants for the PS/2 mouse packet decoder.
// ============================================================================
package ps2md_pkg;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 9;
    localparam logic [CFG_INDEX_W-1:0] CFG_PACKET_MODE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DELTA_LIMIT = 1'd1;

    // Packet mode codes; the unused code behaves as normal mode
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_WHEEL  = 2'd1;
    localparam logic [1:0] MODE_FIVE   = 2'd2;

    localparam logic [8:0] DELTA_LIMIT_RESET = 9'd255;

    // Flag bits in the first packet byte
    localparam int BIT_SIGN_X = 4;
    localparam int BIT_SIGN_Y = 5;
    localparam int BIT_OVF_X  = 6;
    localparam int BIT_OVF_Y  = 7;

    // Extra button bits in the fourth byte (five-button mode)
    localparam int BIT_BTN4 = 4;
    localparam int BIT_BTN5 = 5;

    localparam int DELTA_W = 11;

    // One assembled packet, waiting for decode
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic       wheel;
        logic       five_btn;
    } pkt_t;

    // Decoded per-packet movement and buttons
    typedef struct packed {
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
        logic signed [3:0]         dz;
        logic [4:0]                buttons;
    } dec_t;

endpackage

// ===== hw/rtl/ps2md_decode.sv =====
// ============================================================================
// ps2md_decode
// Decode one assembled packet into clamped X/Y deltas, wheel step and buttons.
// ============================================================================
module ps2md_decode (
    input  ps2md_pkg::pkt_t pkt,
    input  logic [8:0]      delta_limit,
    output ps2md_pkg::dec_t dec
);

    // Signed byte plus or minus 256 on overflow
    function automatic logic signed [ps2md_pkg::DELTA_W-1:0] axis_delta(
        input logic [7:0] data,
        input logic       ovf,
        input logic       sgn
    );
        logic signed [ps2md_pkg::DELTA_W-1:0] v;
        v = {{(ps2md_pkg::DELTA_W-8){data[7]}}, data};
        if (ovf)
        begin
            v = sgn ? v - 11'sd256 : v + 11'sd256;
        end
        return v;
    endfunction

    logic signed [ps2md_pkg::DELTA_W-1:0] lim;
    logic signed [ps2md_pkg::DELTA_W-1:0] neg_lim;
    logic signed [ps2md_pkg::DELTA_W-1:0] raw_x;
    logic signed [ps2md_pkg::DELTA_W-1:0] raw_y;

    assign lim     = $signed({2'b00, delta_limit});
    assign neg_lim = -lim;

    always_comb
    begin
        raw_x = axis_delta(pkt.b1, pkt.b0[ps2md_pkg::BIT_OVF_X], pkt.b0[ps2md_pkg::BIT_SIGN_X]);
        raw_y = -axis_delta(pkt.b2, pkt.b0[ps2md_pkg::BIT_OVF_Y], pkt.b0[ps2md_pkg::BIT_SIGN_Y]);

        if (raw_x < neg_lim)
            dec.dx = neg_lim;
        else if (raw_x > lim)
            dec.dx = lim;
        else
            dec.dx = raw_x;

        if (raw_y < neg_lim)
            dec.dy = neg_lim;
        else if (raw_y > lim)
            dec.dy = lim;
        else
            dec.dy = raw_y;

        // wheel nibble counts only in wheel modes
        dec.dz = pkt.wheel ? $signed(pkt.b3[3:0]) : 4'sd0;

        dec.buttons = {2'b00, pkt.b0[2:0]};
        if (pkt.five_btn)
        begin
            dec.buttons[3] = pkt.b3[ps2md_pkg::BIT_BTN4];
            dec.buttons[4] = pkt.b3[ps2md_pkg::BIT_BTN5];
        end
    end

endmodule

// ===== hw/rtl/ps2_mouse_packet_decoder.sv =====
// ============================================================================
// ps2_mouse_packet_decoder
// Groups received PS/2 mouse bytes into packets, decodes them and keeps
// running X, Y and wheel positions.
// ============================================================================
//
// Channel   Direction  Signals                          Beat carries
// --------  ---------  -------------------------------  --------------------------
// s_*       in         s_tvalid, s_tready, s_tdata[7:0] one received mouse byte
// m_*       out        m_tvalid, m_tready, m_tdata[87:0] positions, wheel, buttons
// cfg_*     in         cfg_valid, cfg_ready, cfg_index,  register write
//                      cfg_data[8:0]
//
// One byte is taken per cycle while s_tready is high. A byte that completes
// a packet is assembled into the packet register at its accept edge; once
// the result register is free, the packet is decoded, the accumulators
// updated and the result loaded with m_tvalid. Reset clears the byte count,
// accumulators and valid flags; packet_mode resets to normal, delta_limit to
// 255. A stalled result blocks input only once a finished packet waits behind
// it in the packet register; until then bytes keep flowing, including the one
// that fills that register. cfg_ready is always high.
// ============================================================================
module ps2_mouse_packet_decoder #(
    parameter int POS_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // byte stream in
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] rx_byte
    // result stream out
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [87:0]                         m_tdata,   // [31:0] pos_x, [63:32] pos_y,
                                                           // [79:64] wheel_z,
                                                           // [84:80] buttons, [87:85] zero
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ps2md_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ps2md_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [1:0] packet_mode_reg;
    logic [8:0] delta_limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            packet_mode_reg <= ps2md_pkg::MODE_NORMAL;
            delta_limit_reg <= ps2md_pkg::DELTA_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ps2md_pkg::CFG_PACKET_MODE: packet_mode_reg <= cfg_data[1:0];
                ps2md_pkg::CFG_DELTA_LIMIT: delta_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake control
    // ------------------------------------------------------------------
    logic pkt_valid_reg;
    logic m_tvalid_reg;
    logic out_free;
    logic advance;
    logic in_accept;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign advance   = pkt_valid_reg && out_free;
    assign s_tready  = !pkt_valid_reg || out_free;
    assign in_accept = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Byte collection and packet assembly
    // ------------------------------------------------------------------
    logic [1:0]       byte_index_reg;
    logic [1:0]       byte_index_next;
    logic [7:0]       packet_bytes_reg [3];
    logic             wheel_mode;
    logic             five_mode;
    logic [1:0]       last_idx;
    logic             pkt_done;
    logic [7:0]       asm_bytes [4];
    ps2md_pkg::pkt_t  pkt_reg;
    ps2md_pkg::pkt_t  pkt_next;

    always_comb
    begin
        wheel_mode = packet_mode_reg inside {ps2md_pkg::MODE_WHEEL, ps2md_pkg::MODE_FIVE};
        five_mode  = (packet_mode_reg == ps2md_pkg::MODE_FIVE);
        last_idx   = wheel_mode ? 2'd3 : 2'd2;
        // a packet ends once the count reaches the current mode's length,
        // even if the mode changed partway through
        pkt_done   = (byte_index_reg >= last_idx);

        // bytes not yet received in this packet read as zero
        for (int i = 0; i < 3; i++)
        begin
            asm_bytes[i] = (2'(i) < byte_index_reg) ? packet_bytes_reg[i] : 8'd0;
        end
        asm_bytes[3]        = 8'd0;
        asm_bytes[last_idx] = s_tdata;

        pkt_next.b0       = asm_bytes[0];
        pkt_next.b1       = asm_bytes[1];
        pkt_next.b2       = asm_bytes[2];
        pkt_next.b3       = asm_bytes[3];
        pkt_next.wheel    = wheel_mode;
        pkt_next.five_btn = five_mode;

        byte_index_next = pkt_done ? 2'd0 : 2'(byte_index_reg + 2'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= 2'd0;
            pkt_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                byte_index_reg <= byte_index_next;
            end
            if (in_accept && pkt_done)
                pkt_valid_reg <= 1'b1;
            else if (advance)
                pkt_valid_reg <= 1'b0;
        end
    end

    // payload: partial bytes and the assembled packet
    always_ff @(posedge clk)
    begin
        if (in_accept && !pkt_done)
        begin
            packet_bytes_reg[byte_index_reg] <= s_tdata;
        end
        if (in_accept && pkt_done)
        begin
            pkt_reg <= pkt_next;
        end
    end

    // ------------------------------------------------------------------
    // Decode and accumulate
    // ------------------------------------------------------------------
    ps2md_pkg::dec_t dec;

    ps2md_decode u_decode (
        .pkt         (pkt_reg),
        .delta_limit (delta_limit_reg),
        .dec         (dec)
    );

    logic signed [POS_WIDTH-1:0] accum_x_reg;
    logic signed [POS_WIDTH-1:0] accum_y_reg;
    logic signed [15:0]          accum_z_reg;
    logic [4:0]                  buttons_reg;

    // accumulators double as the position fields of the result register;
    // they move only when a new result is loaded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_x_reg  <= '0;
            accum_y_reg  <= '0;
            accum_z_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                accum_x_reg  <= accum_x_reg + POS_WIDTH'(dec.dx);
                accum_y_reg  <= accum_y_reg + POS_WIDTH'(dec.dy);
                accum_z_reg  <= accum_z_reg + 16'(dec.dz);
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            buttons_reg <= dec.buttons;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, buttons_reg, accum_z_reg, 32'(accum_y_reg), 32'(accum_x_reg)};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    logic signed [ps2md_pkg::DELTA_W-1:0] lim_chk;
    assign lim_chk = $signed({2'b00, delta_limit_reg});

    // input stalls only when a waiting result blocks the packet register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (pkt_valid_reg && m_tvalid_reg && !m_tready))
        else $error("input stalled without a downstream stall");

    // accumulators hold while the result waits
    a_accum_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !m_tready) |=> ($stable(accum_x_reg) && $stable(accum_y_reg)
                                         && $stable(accum_z_reg)))
        else $error("accumulator moved under a stalled result");

    // a completing byte resets the count and fills the packet register
    a_pkt_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && pkt_done) |=> (pkt_valid_reg && byte_index_reg == 2'd0))
        else $error("packet completion not registered");

    // a decoded packet always yields a result
    a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid_reg)
        else $error("decoded packet lost");

    // clamped deltas stay within the limit
    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid_reg |-> (dec.dx <= lim_chk && dec.dx >= -lim_chk
                           && dec.dy <= lim_chk && dec.dy >= -lim_chk))
        else $error("delta outside clamp limit");

endmodule
